// ===== hdl/rau_pkg.sv =====
// rau_pkg: shared types, codes and constants of the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int DW            = 64;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_LT  = 3'd4;
    localparam logic [2:0] FN_EQ  = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_R = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_SET_ZDEN,
        CMD_SET_DIVZ,
        CMD_SET_OVF,
        CMD_LOAD,
        CMD_GCD_START,
        CMD_DIVN_START,
        CMD_DIVD_START,
        CMD_TAKE_DEN,
        CMD_STORE,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_COMB,
        CMD_CMP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        phase_t  phase;
    } cmd_t;

    typedef struct packed {
        logic       gcd_done;
        logic       div_done;
        logic       x_zero;
        logic       fit_fail;
        logic       zero_den;
        logic [2:0] func;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/rau_gcd.sv =====
// rau_gcd: iterative binary gcd, one subtract-and-shift step per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_gcd (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [rau_pkg::DW-1:0] x_in,
    input  wire logic [rau_pkg::DW-1:0] y_in,
    output logic                        done,
    output logic [rau_pkg::DW-1:0]      g
);
    import rau_pkg::*;

    localparam int KW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] x_reg, y_reg, g_reg;
    logic [KW-1:0] k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                x_reg    <= x_in;
                y_reg    <= y_in;
                k_reg    <= '0;
            end else if (busy_reg) begin
                if (x_reg == '0) begin
                    g_reg    <= y_reg << k_reg;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_reg <= (x_reg - y_reg) >> 1;
                end else begin
                    y_reg <= (y_reg - x_reg) >> 1;
                end
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule
`default_nettype wire

// ===== hdl/rau_div.sv =====
// rau_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [rau_pkg::DW-1:0] dividend,
    input  wire logic [rau_pkg::DW-1:0] divisor,
    output logic                        done,
    output logic [rau_pkg::DW-1:0]      quotient
);
    import rau_pkg::*;

    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] quot_reg, dsr_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    assign rem_sh = {rem_reg[DW-1:0], quot_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quot_reg <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= '1;
            end else if (busy_reg) begin
                if (!diff[DW]) begin
                    rem_reg  <= diff;
                    quot_reg <= {quot_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    quot_reg <= {quot_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ===== hdl/rau_datapath.sv =====
// rau_datapath: operand registers, shared multiplier, normalizer and result registers.
// Depends on rau_pkg, rau_gcd, rau_div.
`default_nettype none
module rau_datapath #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rau_pkg::cmd_t       cmd,
    output rau_pkg::dp_status_t      stat,
    input  wire logic [2:0]          in_func,
    input  wire logic signed [31:0]  in_a_num,
    input  wire logic signed [31:0]  in_a_den,
    input  wire logic signed [31:0]  in_b_num,
    input  wire logic signed [31:0]  in_b_den,
    output logic [31:0]              res_num,
    output logic [30:0]              res_den,
    output logic                     res_cmp,
    output logic [1:0]               res_status
);
    import rau_pkg::*;

    localparam logic [DW-1:0] MAXPOS = (DW'(1) << (WIDTH - 1)) - DW'(1);

    logic [2:0]           func_reg;
    logic signed [31:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic [DW-1:0]        x_num_reg, x_den_reg;
    logic                 x_neg_reg;
    logic signed [31:0]   a_num_reg, b_num_reg;
    logic [30:0]          a_den_reg, b_den_reg;
    logic signed [DW-1:0] p1_reg, p2_reg, p3_reg, pn_reg, pd_reg;
    logic [31:0]          rn_reg;
    logic [30:0]          rd_reg;
    logic                 cmp_reg;
    status_t              st_reg;

    logic signed [DW-1:0] ld_n, ld_d;
    logic [DW-1:0]        ld_nm, ld_dm;
    logic signed [32:0]   ma, mb;
    logic signed [65:0]   prod;
    logic [31:0]          st_num;
    logic                 gcd_done, div_done;
    logic [DW-1:0]        g_val, q_val;
    logic                 gcd_start, div_start;
    logic [DW-1:0]        div_n;

    always_comb begin
        unique case (cmd.phase)
            PH_A: begin
                ld_n = DW'(an_reg);
                ld_d = DW'(ad_reg);
            end
            PH_B: begin
                ld_n = DW'(bn_reg);
                ld_d = DW'(bd_reg);
            end
            default: begin
                ld_n = pn_reg;
                ld_d = pd_reg;
            end
        endcase
    end

    assign ld_nm = ld_n[DW-1] ? DW'(-ld_n) : DW'(ld_n);
    assign ld_dm = ld_d[DW-1] ? DW'(-ld_d) : DW'(ld_d);

    always_comb begin
        unique case (cmd.op)
            CMD_MUL1: begin
                ma = 33'(b_num_reg);
                mb = {2'b00, a_den_reg};
            end
            CMD_MUL2: begin
                ma = {2'b00, a_den_reg};
                mb = (func_reg == FN_DIV) ? 33'(b_num_reg) : {2'b00, b_den_reg};
            end
            default: begin
                ma = 33'(a_num_reg);
                mb = (func_reg == FN_MUL) ? 33'(b_num_reg) : {2'b00, b_den_reg};
            end
        endcase
    end

    assign prod   = ma * mb;
    assign st_num = x_neg_reg ? -x_num_reg[31:0] : x_num_reg[31:0];

    assign gcd_start = (cmd.op == CMD_GCD_START);
    assign div_start = (cmd.op == CMD_DIVN_START) || (cmd.op == CMD_DIVD_START);
    assign div_n     = (cmd.op == CMD_DIVD_START) ? x_den_reg : x_num_reg;

    rau_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .x_in    (x_num_reg),
        .y_in    (x_den_reg),
        .done    (gcd_done),
        .g       (g_val)
    );

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (g_val),
        .done     (div_done),
        .quotient (q_val)
    );

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            CMD_CAPTURE: begin
                func_reg <= in_func;
                an_reg   <= in_a_num;
                ad_reg   <= in_a_den;
                bn_reg   <= in_b_num;
                bd_reg   <= in_b_den;
                rn_reg   <= '0;
                rd_reg   <= '0;
                cmp_reg  <= 1'b0;
                st_reg   <= ST_OK;
            end
            CMD_SET_ZDEN: st_reg <= ST_ZERO_DEN;
            CMD_SET_DIVZ: st_reg <= ST_DIV_ZERO;
            CMD_SET_OVF:  st_reg <= ST_OVERFLOW;
            CMD_LOAD: begin
                x_num_reg <= ld_nm;
                if (ld_nm == '0) begin
                    x_den_reg <= DW'(1);
                    x_neg_reg <= 1'b0;
                end else begin
                    x_den_reg <= ld_dm;
                    x_neg_reg <= ld_n[DW-1] ^ ld_d[DW-1];
                end
            end
            CMD_DIVD_START: x_num_reg <= q_val;
            CMD_TAKE_DEN:   x_den_reg <= q_val;
            CMD_STORE: begin
                unique case (cmd.phase)
                    PH_A: begin
                        a_num_reg <= st_num;
                        a_den_reg <= x_den_reg[30:0];
                    end
                    PH_B: begin
                        b_num_reg <= st_num;
                        b_den_reg <= x_den_reg[30:0];
                    end
                    default: begin
                        rn_reg <= st_num;
                        rd_reg <= x_den_reg[30:0];
                    end
                endcase
            end
            CMD_MUL0: p1_reg <= prod[DW-1:0];
            CMD_MUL1: p2_reg <= prod[DW-1:0];
            CMD_MUL2: p3_reg <= prod[DW-1:0];
            CMD_COMB: begin
                if (func_reg == FN_ADD) begin
                    pn_reg <= p1_reg + p2_reg;
                end else if (func_reg == FN_SUB) begin
                    pn_reg <= p1_reg - p2_reg;
                end else begin
                    pn_reg <= p1_reg;
                end
                pd_reg <= p3_reg;
            end
            CMD_CMP: begin
                if (func_reg == FN_LT) begin
                    cmp_reg <= (p1_reg < p2_reg);
                end else begin
                    cmp_reg <= (a_num_reg == b_num_reg) && (a_den_reg == b_den_reg);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.gcd_done = gcd_done;
        stat.div_done = div_done;
        stat.x_zero   = (x_num_reg == '0);
        stat.fit_fail = (x_den_reg > MAXPOS) || (x_num_reg > (MAXPOS + DW'(x_neg_reg)));
        stat.zero_den = (ad_reg == '0) || (bd_reg == '0);
        stat.func     = func_reg;
    end

    assign res_num    = rn_reg;
    assign res_den    = rd_reg;
    assign res_cmp    = cmp_reg;
    assign res_status = st_reg;

endmodule
`default_nettype wire

// ===== hdl/rau_ctrl.sv =====
// rau_ctrl: sequencing state machine; issues datapath commands, owns the handshakes.
// Depends on rau_pkg.
`default_nettype none
module rau_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire rau_pkg::dp_status_t stat,
    output rau_pkg::cmd_t            cmd
);
    import rau_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CHK  = 13'b0000000000010,
        S_LOAD = 13'b0000000000100,
        S_ZCHK = 13'b0000000001000,
        S_GCD  = 13'b0000000010000,
        S_DIVN = 13'b0000000100000,
        S_DIVD = 13'b0000001000000,
        S_FIT  = 13'b0000010000000,
        S_MUL0 = 13'b0000100000000,
        S_MUL1 = 13'b0001000000000,
        S_MUL2 = 13'b0010000000000,
        S_COMB = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.op     = CMD_NONE;
        cmd.phase  = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = CMD_CAPTURE;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (stat.func > FN_EQ) begin
                    state_next = S_OUT;
                end else if (stat.zero_den) begin
                    cmd.op     = CMD_SET_ZDEN;
                    state_next = S_OUT;
                end else begin
                    phase_next = PH_A;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.op     = CMD_LOAD;
                state_next = S_ZCHK;
            end
            S_ZCHK: begin
                if (stat.x_zero) begin
                    state_next = S_FIT;
                end else begin
                    cmd.op     = CMD_GCD_START;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (stat.gcd_done) begin
                    cmd.op     = CMD_DIVN_START;
                    state_next = S_DIVN;
                end
            end
            S_DIVN: begin
                if (stat.div_done) begin
                    cmd.op     = CMD_DIVD_START;
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                if (stat.div_done) begin
                    cmd.op     = CMD_TAKE_DEN;
                    state_next = S_FIT;
                end
            end
            S_FIT: begin
                if (stat.fit_fail) begin
                    cmd.op     = CMD_SET_OVF;
                    state_next = S_OUT;
                end else begin
                    unique case (phase_reg)
                        PH_A: begin
                            cmd.op     = CMD_STORE;
                            phase_next = PH_B;
                            state_next = S_LOAD;
                        end
                        PH_B: begin
                            if (stat.func == FN_DIV && stat.x_zero) begin
                                cmd.op     = CMD_SET_DIVZ;
                                state_next = S_OUT;
                            end else begin
                                cmd.op     = CMD_STORE;
                                state_next = S_MUL0;
                            end
                        end
                        default: begin
                            cmd.op     = CMD_STORE;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_MUL0: begin
                cmd.op     = CMD_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.op     = CMD_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.op     = CMD_MUL2;
                state_next = S_COMB;
            end
            S_COMB: begin
                if (stat.func >= FN_LT) begin
                    cmd.op     = CMD_CMP;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = CMD_COMB;
                    phase_next = PH_R;
                    state_next = S_LOAD;
                end
            end
            S_OUT: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
// rational_arith_unit: exact add/sub/mul/div and compare of two fractions.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
// Zero denominators and unused codes end without reductions; otherwise up to three reductions,
// each a binary gcd (one step per cycle) and two divisions; a zero numerator skips
// its gcd and divisions. One word in flight.
// Reset: synchronous active-low aresetn returns the controller to idle, no output valid.
`default_nettype none
module rational_arith_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // a_numerator, a_denominator, b_numerator, b_denominator
    input  wire logic [7:0]   s_tuser,  // func, zero fill
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,  // result_numerator, result_denominator, compare_true
    output logic [7:0]        m_tuser   // status, zero fill
);
    import rau_pkg::*;

    cmd_t       cmd;
    dp_status_t stat;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        res_cmp;
    logic [1:0]  res_status;

    rau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser[2:0]),
        .in_a_num   (s_tdata[31:0]),
        .in_a_den   (s_tdata[63:32]),
        .in_b_num   (s_tdata[95:64]),
        .in_b_den   (s_tdata[127:96]),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_cmp    (res_cmp),
        .res_status (res_status)
    );

    assign m_tdata = {res_cmp, res_den, res_num};
    assign m_tuser = {6'b0, res_status};

endmodule
`default_nettype wire

// ===== tb/rational_arith_unit_checker.sv =====
// rational_arith_unit_checker: watches both streams of the rational arithmetic unit,
// predicts every result word from the input word and compares field by field.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [7:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,
    input  wire logic [7:0]   m_tuser,
    output int                errors,
    output int                outstanding
);
    import rau_pkg::*;

    localparam int W = 32;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        cmp;
        status_t     status;
    } rat_result_t;

    rat_result_t pending_q[$];

    initial errors = 0;
    assign outstanding = pending_q.size();

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    // reduce and normalize; 0 when the fraction does not fit W bits
    function automatic bit reduce_frac(input longint n, input longint d,
                                       output longint rn, output longint rd);
        longint unsigned maxpos, nm, dm, x, y, t;
        bit neg;
        maxpos = (64'd1 << (W - 1)) - 1;
        neg = (n < 0) != (d < 0);
        nm = magnitude(n);
        dm = magnitude(d);
        rn = 0;
        rd = 1;
        if (nm == 0) return 1'b1;
        x = nm;
        y = dm;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        if (dm > maxpos) return 1'b0;
        if (neg ? nm > maxpos + 1 : nm > maxpos) return 1'b0;
        rn = neg ? -longint'(nm) : longint'(nm);
        rd = longint'(dm);
        return 1'b1;
    endfunction

    function automatic rat_result_t predict_rational(input logic [127:0] d,
                                                     input logic [2:0] fn);
        rat_result_t r;
        longint an, ad, bn, bd, xn, xd, yn, yd, pn, pd, rn, rd;
        bit ok_a, ok_b;
        an = longint'($signed(d[31:0]));
        ad = longint'($signed(d[63:32]));
        bn = longint'($signed(d[95:64]));
        bd = longint'($signed(d[127:96]));
        r = '0;
        r.status = ST_OK;
        if (fn > FN_EQ) return r;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        ok_a = reduce_frac(an, ad, xn, xd);
        ok_b = reduce_frac(bn, bd, yn, yd);
        if (!ok_a || !ok_b) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        if (fn == FN_LT) begin
            r.cmp = (xn * yd < yn * xd);
            return r;
        end
        if (fn == FN_EQ) begin
            r.cmp = (xn == yn && xd == yd);
            return r;
        end
        if (fn == FN_DIV && yn == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (fn)
            FN_ADD: begin pn = xn * yd + yn * xd; pd = xd * yd; end
            FN_SUB: begin pn = xn * yd - yn * xd; pd = xd * yd; end
            FN_MUL: begin pn = xn * yn; pd = xd * yd; end
            default: begin pn = xn * yd; pd = xd * yn; end
        endcase
        if (reduce_frac(pn, pd, rn, rd)) begin
            r.num = rn[31:0];
            r.den = rd[30:0];
        end else begin
            r.status = ST_OVERFLOW;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        rat_result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("pending words", 0, 1);
                end else begin
                    e = pending_q.pop_front();
                    if (m_tdata[31:0] !== e.num)
                        report_mismatch("numerator", $signed(m_tdata[31:0]), $signed(e.num));
                    if (m_tdata[62:32] !== e.den)
                        report_mismatch("denominator", m_tdata[62:32], e.den);
                    if (m_tdata[63] !== e.cmp)
                        report_mismatch("compare", m_tdata[63], e.cmp);
                    if (m_tuser[1:0] !== e.status)
                        report_mismatch("status", m_tuser[1:0], e.status);
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(predict_rational(s_tdata, s_tuser[2:0]));
        end
    end
endmodule
`default_nettype wire

// ===== tb/rational_arith_unit_tb.sv =====
// rational_arith_unit_tb: drives directed and random fraction words through the
// rational arithmetic unit with varying idle and stall patterns. Depends on rau_pkg,
// rational_arith_unit and rational_arith_unit_checker.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit_tb;
    import rau_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2500;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [7:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [7:0]   m_tuser;
    int           errors;
    int           outstanding;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int words_sent;
    int idle_cycles;

    rational_arith_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rational_arith_unit_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("rational_arith_unit_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [2:0] fn, input logic [31:0] an,
                             input logic [31:0] ad, input logic [31:0] bn,
                             input logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bd, bn, ad, an};
        s_tuser  <= {5'd0, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_operand(input bit is_den);
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2: case ($urandom_range(4))
                   0: v = 32'h8000_0000;
                   1: v = 32'h7fff_ffff;
                   2: v = 32'hffff_ffff;
                   3: v = 32'd1;
                   default: v = 32'h8000_0001;
               endcase
            3: v = 32'($signed($urandom_range(4000)) - 2000) * 32'($urandom_range(1, 60000));
            default: v = 32'($signed($urandom_range(100)) - 50) * 32'($urandom_range(1, 12));
        endcase
        if (is_den && v == 0 && $urandom_range(19) != 0) v = 32'd1;
        return v;
    endfunction

    function automatic logic [2:0] rand_func();
        return ($urandom_range(24) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
    endfunction

    initial begin
        int ph, i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        words_sent     = 0;
        idle_cycles    = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        send_word(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(FN_SUB, 32'd2, 32'd4, -32'd6, -32'd8);
        send_word(FN_MUL, -32'd3, 32'd7, 32'd14, -32'd9);
        send_word(FN_DIV, 32'd5, 32'd6, -32'd10, 32'd3);
        send_word(FN_LT, -32'd1, 32'd2, 32'd1, 32'd3);
        send_word(FN_LT, 32'd1, 32'd3, 32'd1, 32'd3);
        send_word(FN_EQ, 32'd2, 32'd4, -32'd1, -32'd2);
        send_word(FN_EQ, 32'd0, 32'd5, 32'd0, -32'd7);
        send_word(FN_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_word(FN_LT, 32'd1, 32'd1, 32'd1, 32'd0);
        send_word(FN_DIV, 32'd3, 32'd4, 32'd0, 32'd9);
        send_word(FN_ADD, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
        send_word(FN_EQ, 32'd1, 32'd1, 32'h8000_0000, 32'h8000_0000);
        send_word(FN_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        send_word(FN_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        send_word(FN_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_word(FN_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_word(FN_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
        send_word(FN_DIV, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 32'h7fff_ffff);
        send_word(FN_LT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
        send_word(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(3'd7, 32'd5, 32'd0, 32'd3, 32'd0);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 10; recv_stall_pct = 40; end
            endcase
            if (ph == 2) hold_request = 1'b1;
            for (i = 0; i < 110; i++) begin
                send_word(rand_func(), rand_operand(1'b0), rand_operand(1'b1),
                          rand_operand(1'b0), rand_operand(1'b1));
            end
            drain();
        end

        $display("sent %0d words: all six operations, unused codes, zero denominators,",
                 words_sent);
        $display("division by zero and overflow, under varied idle and stall patterns");
        if (errors == 0) begin
            $display("rational_arith_unit_tb: done, clean");
        end else begin
            $display("rational_arith_unit_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
